### hw/rtl/adjacent_duplicate_line_filter_unit_macros.svh
// Assertion macros for the adjacent duplicate line filter checker
`ifndef ADJACENT_DUPLICATE_LINE_FILTER_UNIT_MACROS_SVH
`define ADJACENT_DUPLICATE_LINE_FILTER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ADLF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ADLF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/adlf_pkg.sv
// Shared constants and types of the adjacent duplicate line filter
package adlf_pkg;

    localparam int MAX_LINE  = 256;
    localparam int LEN_W     = $clog2(MAX_LINE);
    localparam int WORD_AW   = LEN_W - 3;
    localparam int MEM_AW    = WORD_AW + 1;
    localparam int WORD_W    = 64;
    localparam int COUNT_W   = 4;
    localparam logic [7:0] NEWLINE = 8'd10;
    localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(MAX_LINE - 1);

    typedef logic [LEN_W-1:0] len_t;

    typedef struct packed {
        logic buf_sel;
        len_t len;
    } desc_t;

    typedef struct packed {
        logic valid;
        logic buf_sel;
    } done_t;

    typedef struct packed {
        logic              en;
        logic [MEM_AW-1:0] addr;
        logic [2:0]        lane;
        logic [7:0]        data;
    } wr_t;

endpackage

### hw/rtl/adlf_line_mem.sv
// Two line buffers packed as eight-byte words: one byte write port, two word read ports
module adlf_line_mem
(
    input  logic                         clk,
    input  adlf_pkg::wr_t                wr,
    input  logic [adlf_pkg::MEM_AW-1:0]  rd_a_addr,
    output logic [adlf_pkg::WORD_W-1:0]  rd_a_data,
    input  logic                         rd_b_en,
    input  logic [adlf_pkg::MEM_AW-1:0]  rd_b_addr,
    output logic [adlf_pkg::WORD_W-1:0]  rd_b_data
);

    logic [adlf_pkg::WORD_W-1:0] store_reg [0:(1 << adlf_pkg::MEM_AW)-1];
    logic [adlf_pkg::WORD_W-1:0] rd_a_data_reg;
    logic [adlf_pkg::WORD_W-1:0] rd_b_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            store_reg[wr.addr][{wr.lane, 3'b000} +: 8] <= wr.data;
        end
        rd_a_data_reg <= store_reg[rd_a_addr];
        if (rd_b_en)
        begin
            rd_b_data_reg <= store_reg[rd_b_addr];
        end
    end

    assign rd_a_data = rd_a_data_reg;
    assign rd_b_data = rd_b_data_reg;

endmodule

### hw/rtl/adlf_queue.sv
// Two-entry queue of line descriptors between front and back
module adlf_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  adlf_pkg::desc_t push_desc,
    input  logic            pop,
    output logic            head_valid,
    output adlf_pkg::desc_t head_desc,
    output logic            full
);

    adlf_pkg::desc_t entry_reg [0:1];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    assign head_valid = (count_reg != 2'd0);
    assign head_desc  = entry_reg[rd_ptr_reg];
    assign full       = (count_reg == 2'd2);

endmodule

### hw/rtl/adlf_front.sv
// Front end: accept bytes, build lines, compare with previous line, queue lines to emit
module adlf_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [7:0]                   data_byte,
    input  logic                         end_of_stream,
    output adlf_pkg::wr_t                wr,
    output logic [adlf_pkg::MEM_AW-1:0]  rd_addr,
    input  logic [adlf_pkg::WORD_W-1:0]  rd_data,
    output logic                         push,
    output adlf_pkg::desc_t              push_desc,
    input  logic                         q_full,
    input  adlf_pkg::done_t              done
);

    adlf_pkg::len_t line_len_reg;
    adlf_pkg::len_t line_len_next;
    adlf_pkg::len_t prev_len_reg;
    adlf_pkg::len_t prev_len_next;
    logic           have_prev_reg;
    logic           have_prev_next;
    logic           mismatch_reg;
    logic           mismatch_next;
    logic           cmp_valid_reg;
    logic           cmp_valid_next;
    logic [7:0]     cmp_byte_reg;
    logic [7:0]     cmp_byte_next;
    logic [2:0]     cmp_off_reg;
    logic [2:0]     cmp_off_next;
    logic           wsel_reg;
    logic           wsel_next;
    logic [1:0]     busy_reg;
    logic [1:0]     busy_next;

    logic           is_newline;
    logic           pend_mis;
    logic           same;
    logic           finish;
    logic           emit;
    logic           store;
    logic           tgt;
    logic           accept;
    adlf_pkg::len_t idx;

    always_comb
    begin
        is_newline = (data_byte == adlf_pkg::NEWLINE);
        pend_mis   = cmp_valid_reg && (rd_data[{cmp_off_reg, 3'b000} +: 8] != cmp_byte_reg);
        same       = have_prev_reg && (prev_len_reg == line_len_reg)
                     && !(mismatch_reg || pend_mis);
        if (end_of_stream)
        begin
            finish = (line_len_reg != '0);
        end
        else if (is_newline)
        begin
            finish = 1'b1;
        end
        else
        begin
            finish = (line_len_reg == adlf_pkg::FULL_LEN);
        end
        emit     = finish && !same;
        store    = !end_of_stream && !is_newline;
        tgt      = (emit && !end_of_stream) ? ~wsel_reg : wsel_reg;
        in_stall = (emit && (busy_reg[wsel_reg] || q_full)) || (store && busy_reg[tgt]);
        accept   = in_valid && !in_stall;
        idx      = finish ? '0 : line_len_reg;

        line_len_next  = line_len_reg;
        prev_len_next  = prev_len_reg;
        have_prev_next = have_prev_reg;
        mismatch_next  = mismatch_reg || pend_mis;
        cmp_valid_next = 1'b0;
        cmp_byte_next  = data_byte;
        cmp_off_next   = idx[2:0];
        wsel_next      = wsel_reg;
        busy_next      = busy_reg;
        wr.en          = 1'b0;
        wr.addr        = {tgt, idx[adlf_pkg::LEN_W-1:3]};
        wr.lane        = idx[2:0];
        wr.data        = data_byte;
        rd_addr        = {~tgt, idx[adlf_pkg::LEN_W-1:3]};
        push           = accept && emit;
        push_desc.buf_sel = wsel_reg;
        push_desc.len     = line_len_reg;

        if (done.valid)
        begin
            busy_next[done.buf_sel] = 1'b0;
        end
        if (push)
        begin
            busy_next[wsel_reg] = 1'b1;
        end

        if (accept)
        begin
            if (end_of_stream)
            begin
                line_len_next  = '0;
                prev_len_next  = '0;
                have_prev_next = 1'b0;
                mismatch_next  = 1'b0;
            end
            else
            begin
                if (finish)
                begin
                    line_len_next = '0;
                    mismatch_next = 1'b0;
                    if (emit)
                    begin
                        prev_len_next  = line_len_reg;
                        have_prev_next = 1'b1;
                        wsel_next      = ~wsel_reg;
                    end
                end
                if (store)
                begin
                    wr.en          = 1'b1;
                    line_len_next  = idx + adlf_pkg::LEN_W'(1);
                    cmp_valid_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_len_reg  <= '0;
            prev_len_reg  <= '0;
            have_prev_reg <= 1'b0;
            mismatch_reg  <= 1'b0;
            cmp_valid_reg <= 1'b0;
            wsel_reg      <= 1'b0;
            busy_reg      <= 2'b00;
        end
        else
        begin
            line_len_reg  <= line_len_next;
            prev_len_reg  <= prev_len_next;
            have_prev_reg <= have_prev_next;
            mismatch_reg  <= mismatch_next;
            cmp_valid_reg <= cmp_valid_next;
            wsel_reg      <= wsel_next;
            busy_reg      <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_byte_reg <= cmp_byte_next;
        cmp_off_reg  <= cmp_off_next;
    end

endmodule

### hw/rtl/adlf_back.sv
// Back end: read queued lines word by word and drive the output channel
module adlf_back
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         head_valid,
    input  adlf_pkg::desc_t              head_desc,
    output adlf_pkg::done_t              done,
    output logic                         rd_en,
    output logic [adlf_pkg::MEM_AW-1:0]  rd_addr,
    input  logic [adlf_pkg::WORD_W-1:0]  rd_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [adlf_pkg::WORD_W-1:0]  out_word,
    output logic [adlf_pkg::COUNT_W-1:0] byte_count,
    output logic                         last
);

    logic [adlf_pkg::WORD_AW-1:0] word_idx_reg;
    logic [adlf_pkg::WORD_AW-1:0] word_idx_next;
    logic                         inflight_reg;
    logic                         inflight_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [adlf_pkg::WORD_W-1:0]  out_word_reg;
    logic [adlf_pkg::WORD_W-1:0]  out_word_next;
    logic [adlf_pkg::COUNT_W-1:0] byte_count_reg;
    logic [adlf_pkg::COUNT_W-1:0] byte_count_next;
    logic                         last_reg;
    logic                         last_next;
    logic                         is_last;
    adlf_pkg::len_t               pos;

    always_comb
    begin
        is_last = (word_idx_reg == head_desc.len[adlf_pkg::LEN_W-1:3]);
        out_word_next = '0;
        for (int k = 0; k < 8; k++)
        begin
            pos = {word_idx_reg, 3'(k)};
            if (pos < head_desc.len)
            begin
                out_word_next[8*k +: 8] = rd_data[8*k +: 8];
            end
            else if (pos == head_desc.len)
            begin
                out_word_next[8*k +: 8] = adlf_pkg::NEWLINE;
            end
        end
        byte_count_next = is_last ? ({1'b0, head_desc.len[2:0]} + 4'd1) : 4'd8;
        last_next       = is_last;

        rd_en   = head_valid && !inflight_reg && (!out_valid_reg || !out_stall);
        rd_addr = {head_desc.buf_sel, word_idx_reg};

        word_idx_next  = word_idx_reg;
        inflight_next  = rd_en;
        out_valid_next = out_valid_reg && out_stall;
        done.valid     = 1'b0;
        done.buf_sel   = head_desc.buf_sel;
        if (inflight_reg)
        begin
            out_valid_next = 1'b1;
            if (is_last)
            begin
                done.valid    = 1'b1;
                word_idx_next = '0;
            end
            else
            begin
                word_idx_next = word_idx_reg + adlf_pkg::WORD_AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_idx_reg  <= '0;
            inflight_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            word_idx_reg  <= word_idx_next;
            inflight_reg  <= inflight_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (inflight_reg)
        begin
            out_word_reg   <= out_word_next;
            byte_count_reg <= byte_count_next;
            last_reg       <= last_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_word   = out_word_reg;
    assign byte_count = byte_count_reg;
    assign last       = last_reg;

endmodule

### hw/rtl/adjacent_duplicate_line_filter_unit.sv
// Top level of the adjacent duplicate line filter
// Input channel: one text byte (data_byte) or an end marker (end_of_stream) per
// transaction, accepted when in_valid is high and in_stall is low.
// Output channel: packed words of an emitted line, lowest byte first; byte_count
// gives the valid bytes, last marks the word with the line's trailing newline.
// A line that equals the line emitted before it produces no words.
// Input rate: one transaction per cycle. in_stall rises only when the line buffer
// the next byte goes to, or the line to be queued, still waits for the back end.
// Output: the back end's port on the line buffer memory reads, then loads a word;
// no new word is read while a read is in flight or a stalled word is held.
// A queued line is read by the back end into its output registers word by word;
// a line of L bytes gives ceil((L+1)/8) words.
// Reset clears lengths, compare state, the queue and the output valid; buffer
// contents are not cleared and need no clearing pass.
// While out_stall is high the output word holds; the front keeps taking bytes
// until both line buffers are taken.
module adjacent_duplicate_line_filter_unit
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [7:0]                   data_byte,
    input  logic                         end_of_stream,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [adlf_pkg::WORD_W-1:0]  out_word,
    output logic [adlf_pkg::COUNT_W-1:0] byte_count,
    output logic                         last
);

    adlf_pkg::wr_t                wr;
    logic [adlf_pkg::MEM_AW-1:0]  rd_a_addr;
    logic [adlf_pkg::WORD_W-1:0]  rd_a_data;
    logic                         rd_b_en;
    logic [adlf_pkg::MEM_AW-1:0]  rd_b_addr;
    logic [adlf_pkg::WORD_W-1:0]  rd_b_data;
    logic                         push;
    adlf_pkg::desc_t              push_desc;
    logic                         q_full;
    logic                         head_valid;
    adlf_pkg::desc_t              head_desc;
    adlf_pkg::done_t              done;

    adlf_line_mem u_mem
    (
        .clk       (clk),
        .wr        (wr),
        .rd_a_addr (rd_a_addr),
        .rd_a_data (rd_a_data),
        .rd_b_en   (rd_b_en),
        .rd_b_addr (rd_b_addr),
        .rd_b_data (rd_b_data)
    );

    adlf_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .wr            (wr),
        .rd_addr       (rd_a_addr),
        .rd_data       (rd_a_data),
        .push          (push),
        .push_desc     (push_desc),
        .q_full        (q_full),
        .done          (done)
    );

    adlf_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_desc  (push_desc),
        .pop        (done.valid),
        .head_valid (head_valid),
        .head_desc  (head_desc),
        .full       (q_full)
    );

    adlf_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_desc  (head_desc),
        .done       (done),
        .rd_en      (rd_b_en),
        .rd_addr    (rd_b_addr),
        .rd_data    (rd_b_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_word   (out_word),
        .byte_count (byte_count),
        .last       (last)
    );

endmodule

### hw/rtl/adlf_checker.sv
// Port-level checks on the output channel, bound to the top level
`include "adjacent_duplicate_line_filter_unit_macros.svh"

module adlf_checker
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [adlf_pkg::WORD_W-1:0]  out_word,
    input logic [adlf_pkg::COUNT_W-1:0] byte_count,
    input logic                         last
);

    `ADLF_ASSERT_NOW(a_count_range, out_valid, (byte_count >= 4'd1) && (byte_count <= 4'd8), "byte_count out of range")
    `ADLF_ASSERT_NOW(a_inner_full, out_valid && !last, byte_count == 4'd8, "word before last not full")
    `ADLF_ASSERT_NOW(a_pad_zero, out_valid, (out_word >> {byte_count, 3'b000}) == 64'd0, "unused bytes not zero")
    `ADLF_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_word) && $stable(byte_count) && $stable(last), "stalled transaction changed")

endmodule

bind adjacent_duplicate_line_filter_unit adlf_checker u_checker (.*);

### verif/tb_top.sv
// Self-checking testbench for the adjacent duplicate line filter unit
module tb_top;

    localparam int QUIET_LIMIT = 4000;
    localparam int CALM_FROM   = 300;
    localparam int CALM_TO     = 400;

    typedef struct packed {
        logic [7:0] data;
        logic       eos;
    } stim_t;

    typedef struct packed {
        logic [adlf_pkg::WORD_W-1:0]  word;
        logic [adlf_pkg::COUNT_W-1:0] count;
        logic                         fin;
    } owed_t;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic [7:0]                   data_byte;
    logic                         end_of_stream;
    logic                         out_valid;
    logic                         out_stall;
    logic [adlf_pkg::WORD_W-1:0]  out_word;
    logic [adlf_pkg::COUNT_W-1:0] byte_count;
    logic                         last;

    stim_t byte_stream[$];
    owed_t owed_words[$];
    stim_t next_item;
    owed_t head;

    logic [7:0] cur_line[adlf_pkg::MAX_LINE];
    logic [7:0] prev_line[adlf_pkg::MAX_LINE];
    int         cur_len;
    int         prev_len;
    bit         have_prev;

    bit in_took;
    bit out_took;
    int items_taken;
    int quiet_cycles;
    int errors;

    adjacent_duplicate_line_filter_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_word      (out_word),
        .byte_count    (byte_count),
        .last          (last)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    function automatic bit calm();
        return items_taken >= CALM_FROM && items_taken < CALM_TO;
    endfunction

    function automatic logic [7:0] text_byte(input bit narrow);
        logic [7:0] b;
        b = narrow ? 8'(8'h61 + $urandom_range(0, 2)) : 8'($urandom_range(0, 255));
        if (b == adlf_pkg::NEWLINE)
            b = b ^ 8'h20;
        return b;
    endfunction

    task automatic push_byte(input logic [7:0] b);
        stim_t s;
        s.data = b;
        s.eos  = 1'b0;
        byte_stream.push_back(s);
    endtask

    task automatic push_end(input logic [7:0] b);
        stim_t s;
        s.data = b;
        s.eos  = 1'b1;
        byte_stream.push_back(s);
    endtask

    task automatic push_line(input logic [7:0] q[$]);
        foreach (q[i])
            push_byte(q[i]);
        push_byte(adlf_pkg::NEWLINE);
    endtask

    task automatic push_text(input string s, input bit with_newline);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
        if (with_newline)
            push_byte(adlf_pkg::NEWLINE);
    endtask

    // finish the current line: emit it as words unless it repeats the previous one
    task automatic close_line();
        bit    same;
        owed_t w;
        int    k;
        int    total;
        same = have_prev && (prev_len == cur_len);
        for (int i = 0; i < cur_len; i++)
            if (cur_line[i] !== prev_line[i])
                same = 0;
        if (!same)
        begin
            total = cur_len + 1;
            w = '0;
            k = 0;
            for (int i = 0; i < total; i++)
            begin
                w.word[8*k +: 8] = (i < cur_len) ? cur_line[i] : adlf_pkg::NEWLINE;
                k++;
                if (k == 8 || i == total - 1)
                begin
                    w.count = adlf_pkg::COUNT_W'(k);
                    w.fin   = (i == total - 1);
                    owed_words.push_back(w);
                    w = '0;
                    k = 0;
                end
            end
            for (int i = 0; i < cur_len; i++)
                prev_line[i] = cur_line[i];
            prev_len  = cur_len;
            have_prev = 1;
        end
        cur_len = 0;
    endtask

    task automatic absorb_transaction(input logic [7:0] b, input logic eos);
        if (eos)
        begin
            if (cur_len > 0)
                close_line();
            cur_len   = 0;
            prev_len  = 0;
            have_prev = 0;
        end
        else if (b == adlf_pkg::NEWLINE)
        begin
            close_line();
        end
        else
        begin
            if (cur_len + 1 >= adlf_pkg::MAX_LINE)
                close_line();
            cur_line[cur_len] = b;
            cur_len++;
        end
    endtask

    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_took))
        begin
            if (byte_stream.size() > 0 && (calm() || $urandom_range(0, 99) >= 37))
            begin
                next_item = byte_stream.pop_front();
                in_valid      <= 1'b1;
                data_byte     <= next_item.data;
                end_of_stream <= next_item.eos;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
        out_stall <= rst_n && !calm() && ($urandom_range(0, 99) < 37);
    end

    always @(posedge clk)
    begin
        in_took  = 0;
        out_took = 0;
        if (rst_n)
        begin
            in_took  = in_valid && !in_stall;
            out_took = out_valid && !out_stall;
            if (in_took)
            begin
                absorb_transaction(data_byte, end_of_stream);
                items_taken++;
            end
            if (out_took)
            begin
                if (owed_words.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected word: expected none, actual %h count %0d last %0b",
                             $time, out_word, byte_count, last);
                end
                else
                begin
                    head = owed_words.pop_front();
                    if (out_word !== head.word)
                    begin
                        errors++;
                        $display("%0t: out_word expected %h actual %h",
                                 $time, head.word, out_word);
                    end
                    if (byte_count !== head.count)
                    begin
                        errors++;
                        $display("%0t: byte_count expected %0d actual %0d",
                                 $time, head.count, byte_count);
                    end
                    if (last !== head.fin)
                    begin
                        errors++;
                        $display("%0t: last expected %0b actual %0b",
                                 $time, head.fin, last);
                    end
                end
            end
            if (in_took || out_took)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: watchdog expired with %0d words outstanding",
                         $time, owed_words.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        logic [7:0] recent[$];
        logic [7:0] fresh[$];
        logic [7:0] big[$];
        int         pick;
        int         len;
        bit         narrow;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        data_byte     = '0;
        end_of_stream = 1'b0;
        out_stall     = 1'b0;
        cur_len       = 0;
        prev_len      = 0;
        have_prev     = 0;
        items_taken   = 0;
        quiet_cycles  = 0;
        errors        = 0;

        push_text("a", 1);
        push_text("a", 1);
        push_text("", 1);
        push_text("", 1);
        push_byte(8'h00);
        push_byte(adlf_pkg::NEWLINE);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(adlf_pkg::NEWLINE);
        push_text("abcdefg", 1);
        push_end(adlf_pkg::NEWLINE);
        push_text("xy", 0);
        push_end(8'h00);
        push_text("xy", 1);

        // overflow the line store; the next byte starts a new line
        for (int i = 0; i < adlf_pkg::MAX_LINE - 1; i++)
            big.push_back(text_byte(0));
        foreach (big[i])
            push_byte(big[i]);
        push_text("xy", 1);

        while (byte_stream.size() < 470)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                repeat ($urandom_range(0, 3))
                    push_byte(text_byte(0));
                push_end(8'($urandom_range(0, 255)));
            end
            else if (pick < 45 && recent.size() > 0)
            begin
                push_line(recent);
            end
            else if (pick < 55)
            begin
                repeat ($urandom_range(1, 4))
                    push_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                len    = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 9);
                narrow = $urandom_range(0, 1);
                fresh.delete();
                repeat (len)
                    fresh.push_back(text_byte(narrow));
                recent = fresh;
                push_line(fresh);
            end
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (byte_stream.size() != 0 || in_valid)
            @(posedge clk);
        while (owed_words.size() != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
